// ===== rtl/sredge_pkg.sv =====
// Shared constants for the segment versus rectangle edge intersection block.
`timescale 1ns / 1ps

package sredge_pkg;

   localparam int CoordBitsDefault = 16;
   localparam int NumEdges         = 4;
   localparam int NumFields        = 8;
   localparam int RspDataBits      = 8;

   typedef enum logic [1:0] {
      EDGE_TOP    = 2'd0,
      EDGE_RIGHT  = 2'd1,
      EDGE_BOTTOM = 2'd2,
      EDGE_LEFT   = 2'd3
   } edge_type;

endpackage

// ===== rtl/segment_rect_edge_intersect.sv =====
// Top level: pipelined test of a line segment against the closed edges of a rectangle.
`timescale 1ns / 1ps

// Each req transaction carries segment endpoints A, B and two opposite rectangle corners P, Q;
// each rsp transaction returns hits_edge, set when the segment touches or crosses any of the
// four closed edges. A segment wholly inside the rectangle returns 0. The block takes one
// transaction per cycle while rsp is not stalled and returns results in order. The four register
// stages are corner sort, coordinate differences and edge compares, four signed multiplies of
// (COORD_BITS+1) bits, and the cross-product sign compare into the output register. Each stage
// holds its item while the next one is full and stalled, so bubbles collapse and a stalled output
// does not block intake until the pipe is full.
module segment_rect_edge_intersect
   import sredge_pkg::*;
#(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // seg_ax, seg_ay, seg_bx, seg_by, corner_px, corner_py, corner_qx, corner_qy
   input  logic [NumFields*COORD_BITS-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hits_edge, then zero fill
   output logic [RspDataBits-1:0]          rsp_tdata
);

   localparam int CB = COORD_BITS;
   localparam int DB = COORD_BITS + 1;
   localparam int PB = 2 * DB;

   logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by, in_px, in_py, in_qx, in_qy;

   assign in_ax = req_tdata[0*CB +: CB];
   assign in_ay = req_tdata[1*CB +: CB];
   assign in_bx = req_tdata[2*CB +: CB];
   assign in_by = req_tdata[3*CB +: CB];
   assign in_px = req_tdata[4*CB +: CB];
   assign in_py = req_tdata[5*CB +: CB];
   assign in_qx = req_tdata[6*CB +: CB];
   assign in_qy = req_tdata[7*CB +: CB];

   // stage handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign v1_in = rdy1 ? req_tvalid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: sort corners, segment extent, direction
   logic signed [CB-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [CB-1:0] lft_ff, rgt_ff, bot_ff, top_ff;
   logic signed [CB-1:0] sxmin_ff, sxmax_ff, symin_ff, symax_ff;
   logic signed [DB-1:0] dx_ff, dy_ff;
   logic signed [CB-1:0] lft_in, rgt_in, bot_in, top_in;
   logic signed [CB-1:0] sxmin_in, sxmax_in, symin_in, symax_in;
   logic signed [DB-1:0] dx_in, dy_in;

   always_comb begin
      lft_in   = (in_px < in_qx) ? in_px : in_qx;
      rgt_in   = (in_px < in_qx) ? in_qx : in_px;
      bot_in   = (in_py < in_qy) ? in_py : in_qy;
      top_in   = (in_py < in_qy) ? in_qy : in_py;
      sxmin_in = (in_ax < in_bx) ? in_ax : in_bx;
      sxmax_in = (in_ax < in_bx) ? in_bx : in_ax;
      symin_in = (in_ay < in_by) ? in_ay : in_by;
      symax_in = (in_ay < in_by) ? in_by : in_ay;
      dx_in    = DB'(in_bx) - DB'(in_ax);
      dy_in    = DB'(in_by) - DB'(in_ay);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ax_ff    <= in_ax;
         ay_ff    <= in_ay;
         bx_ff    <= in_bx;
         by_ff    <= in_by;
         lft_ff   <= lft_in;
         rgt_ff   <= rgt_in;
         bot_ff   <= bot_in;
         top_ff   <= top_in;
         sxmin_ff <= sxmin_in;
         sxmax_ff <= sxmax_in;
         symin_ff <= symin_in;
         symax_ff <= symax_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end
   end

   // stage 2: corner offsets from A, quick reject, per-edge box and side tests
   logic signed [DB-1:0] xl_ff, xr_ff, yt_ff, yb_ff, dx2_ff, dy2_ff;
   logic signed [DB-1:0] xl_in, xr_in, yt_in, yb_in;
   logic [NumEdges-1:0]  pre2_ff, pre2_in;
   logic                 quick2_ff, quick2_in;
   logic [NumEdges-1:0]  box_ok, side_rej;

   always_comb begin
      xl_in = DB'(lft_ff) - DB'(ax_ff);
      xr_in = DB'(rgt_ff) - DB'(ax_ff);
      yt_in = DB'(top_ff) - DB'(ay_ff);
      yb_in = DB'(bot_ff) - DB'(ay_ff);

      quick2_in = (symin_ff > top_ff) || (symax_ff < bot_ff) ||
                  (sxmin_ff > rgt_ff) || (sxmax_ff < lft_ff);

      box_ok[EDGE_TOP]    = !((sxmax_ff < lft_ff) || (rgt_ff < sxmin_ff) ||
                              (symax_ff < top_ff) || (top_ff < symin_ff));
      box_ok[EDGE_RIGHT]  = !((sxmax_ff < rgt_ff) || (rgt_ff < sxmin_ff) ||
                              (symax_ff < bot_ff) || (top_ff < symin_ff));
      box_ok[EDGE_BOTTOM] = !((sxmax_ff < lft_ff) || (rgt_ff < sxmin_ff) ||
                              (symax_ff < bot_ff) || (bot_ff < symin_ff));
      box_ok[EDGE_LEFT]   = !((sxmax_ff < lft_ff) || (lft_ff < sxmin_ff) ||
                              (symax_ff < bot_ff) || (top_ff < symin_ff));

      side_rej[EDGE_TOP]    = (rgt_ff != lft_ff) &&
                              (((ay_ff > top_ff) && (by_ff > top_ff)) ||
                               ((ay_ff < top_ff) && (by_ff < top_ff)));
      side_rej[EDGE_RIGHT]  = (top_ff != bot_ff) &&
                              (((ax_ff > rgt_ff) && (bx_ff > rgt_ff)) ||
                               ((ax_ff < rgt_ff) && (bx_ff < rgt_ff)));
      side_rej[EDGE_BOTTOM] = (rgt_ff != lft_ff) &&
                              (((ay_ff > bot_ff) && (by_ff > bot_ff)) ||
                               ((ay_ff < bot_ff) && (by_ff < bot_ff)));
      side_rej[EDGE_LEFT]   = (top_ff != bot_ff) &&
                              (((ax_ff > lft_ff) && (bx_ff > lft_ff)) ||
                               ((ax_ff < lft_ff) && (bx_ff < lft_ff)));

      pre2_in = box_ok & ~side_rej;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         xl_ff     <= xl_in;
         xr_ff     <= xr_in;
         yt_ff     <= yt_in;
         yb_ff     <= yb_in;
         dx2_ff    <= dx_ff;
         dy2_ff    <= dy_ff;
         pre2_ff   <= pre2_in;
         quick2_ff <= quick2_in;
      end
   end

   // stage 3: cross-product terms
   logic signed [PB-1:0] pxl_ff, pxr_ff, pyt_ff, pyb_ff;
   logic signed [PB-1:0] pxl_in, pxr_in, pyt_in, pyb_in;
   logic [NumEdges-1:0]  pre3_ff;
   logic                 quick3_ff;

   always_comb begin
      pxl_in = PB'(xl_ff) * PB'(dy2_ff);
      pxr_in = PB'(xr_ff) * PB'(dy2_ff);
      pyt_in = PB'(yt_ff) * PB'(dx2_ff);
      pyb_in = PB'(yb_ff) * PB'(dx2_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         pxl_ff    <= pxl_in;
         pxr_ff    <= pxr_in;
         pyt_ff    <= pyt_in;
         pyb_ff    <= pyb_in;
         pre3_ff   <= pre2_ff;
         quick3_ff <= quick2_ff;
      end
   end

   // stage 4: corner side of line AB, combine into result
   logic pos_lt, neg_lt, pos_rt, neg_rt, pos_rb, neg_rb, pos_lb, neg_lb;
   logic [NumEdges-1:0] line_ok;
   logic hit_ff, hit_in;

   always_comb begin
      pos_lt = pxl_ff > pyt_ff;
      neg_lt = pxl_ff < pyt_ff;
      pos_rt = pxr_ff > pyt_ff;
      neg_rt = pxr_ff < pyt_ff;
      pos_rb = pxr_ff > pyb_ff;
      neg_rb = pxr_ff < pyb_ff;
      pos_lb = pxl_ff > pyb_ff;
      neg_lb = pxl_ff < pyb_ff;

      line_ok[EDGE_TOP]    = !((pos_lt && pos_rt) || (neg_lt && neg_rt));
      line_ok[EDGE_RIGHT]  = !((pos_rt && pos_rb) || (neg_rt && neg_rb));
      line_ok[EDGE_BOTTOM] = !((pos_rb && pos_lb) || (neg_rb && neg_lb));
      line_ok[EDGE_LEFT]   = !((pos_lb && pos_lt) || (neg_lb && neg_lt));

      hit_in = !quick3_ff && (|(pre3_ff & line_ok));
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         hit_ff <= hit_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{(RspDataBits-1){1'b0}}, hit_ff};

   a_intake_blocked_only_when_full : assert property (
      @(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && rsp_tvalid && !rsp_tready))
      else $error("intake blocked while pipeline has room");

   a_stage3_holds_on_stall : assert property (
      @(posedge clock) disable iff (reset)
      (v3_ff && !rdy3) |=> (v3_ff && $stable(pxl_ff) && $stable(pyb_ff)))
      else $error("stage 3 changed while stalled");

   a_output_advances_on_take : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !v3_ff) |=> !rsp_tvalid)
      else $error("result repeated after transaction");

   a_zero_fill : assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RspDataBits-1:1] == '0))
      else $error("rsp fill bits not zero");

endmodule
